[rtl/cqs_pkg.sv]
// Package for the circular queue with search.
// Sizes, item kinds, result status codes and the pointer wrap helper.
// No dependencies.
package cqs_pkg;

    localparam int DEPTH    = 8;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int KIND_W   = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 3;
    localparam int OCC_W    = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ  = 2'd0,
        KIND_DEQ  = 2'd1,
        KIND_SRCH = 2'd2,
        KIND_DISP = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE    = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_EMPTY   = 3'd2,
        STAT_MATCH   = 3'd3,
        STAT_NOMATCH = 3'd4,
        STAT_LISTED  = 3'd5
    } status_t;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

[rtl/cqs_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module cqs_ram #(
    parameter int  DATA_W    = 32,
    parameter int  NUM_WORDS = 8,
    localparam int ADDR_W    = $clog2(NUM_WORDS)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [NUM_WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/circular_queue_with_search.sv]
// Top level of the circular queue with search: control, pointers, result register.
// Depends on cqs_pkg and cqs_ram.
//
// channel   direction  handshake          word
// command   in         start & !busy      kind, value
// result    out        strobe (1 cycle)   status, data, slot, occupancy, last
//
// Enqueue: the result is registered in the cycle after acceptance.
// Dequeue: passes through S_DEQ, since the read of the slot RAM is registered.
// Search: S_SCAN over the occupancy, then S_FIN; display: S_SCAN only; one RAM read
// per cycle walks the entries from head to tail. Empty-queue cases answer from S_IDLE.
// Reset clears pointers, count and control; slot contents stay undefined.
// The receiver cannot stall: each result is valid for exactly one cycle.
module circular_queue_with_search (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cqs_pkg::KIND_W-1:0]    kind,
    input  logic signed [cqs_pkg::WORD_W-1:0] value,
    output logic                          busy,
    output logic                          strobe,
    output logic [cqs_pkg::STATUS_W-1:0]  status,
    output logic signed [cqs_pkg::WORD_W-1:0] data,
    output logic [cqs_pkg::SLOT_W-1:0]    slot,
    output logic [cqs_pkg::OCC_W-1:0]     occupancy,
    output logic                          last
);
    import cqs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DEQ  = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [PTR_W-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [WORD_W-1:0] key_reg, key_next;
    logic              srch_reg, srch_next;
    logic              pend_reg, pend_next;
    logic [PTR_W-1:0]  pend_slot_reg, pend_slot_next;

    logic              strobe_reg, strobe_next;
    status_t           status_reg, status_next;
    logic [WORD_W-1:0] data_reg, data_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic              last_reg, last_next;

    logic              wr_en;
    logic [PTR_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_data;

    cqs_ram #(
        .DATA_W    (WORD_W),
        .NUM_WORDS (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next address: walk on during a scan, otherwise keep the head word ready.
    assign rd_addr = (state_reg == S_SCAN) ? next_ptr(cur_reg) : head_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        cur_next       = cur_reg;
        left_next      = left_reg;
        key_next       = key_reg;
        srch_next      = srch_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        wr_en          = 1'b0;

        strobe_next    = 1'b0;
        status_next    = status_reg;
        data_next      = data_reg;
        slot_next      = slot_reg;
        occ_next       = occ_reg;
        last_next      = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    strobe_next = 1'b1;
                    data_next   = '0;
                    slot_next   = '0;
                    occ_next    = OCC_W'(fill_reg);
                    last_next   = 1'b1;
                    case (kind_t'(kind))
                        KIND_ENQ:
                        begin
                            if (fill_reg == CNT_W'(DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                tail_next   = next_ptr(tail_reg);
                                fill_next   = fill_reg + 1'b1;
                                status_next = STAT_DONE;
                                occ_next    = OCC_W'(fill_reg + 1'b1);
                            end
                        end
                        KIND_DEQ:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                strobe_next = 1'b0;
                                head_next   = next_ptr(head_reg);
                                fill_next   = fill_reg - 1'b1;
                                state_next  = S_DEQ;
                            end
                        end
                        KIND_SRCH, KIND_DISP:
                        begin
                            srch_next = (kind_t'(kind) == KIND_SRCH);
                            if (fill_reg == '0)
                            begin
                                status_next = (kind_t'(kind) == KIND_SRCH) ?
                                              STAT_NOMATCH : STAT_EMPTY;
                            end
                            else
                            begin
                                strobe_next = 1'b0;
                                key_next    = value;
                                cur_next    = head_reg;
                                left_next   = fill_reg;
                                pend_next   = 1'b0;
                                state_next  = S_SCAN;
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b0;
                        end
                    endcase
                end
            end

            S_DEQ:
            begin
                strobe_next = 1'b1;
                status_next = STAT_DONE;
                data_next   = rd_data;
                slot_next   = '0;
                occ_next    = OCC_W'(fill_reg);
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end

            S_SCAN:
            begin
                cur_next  = next_ptr(cur_reg);
                left_next = left_reg - 1'b1;
                occ_next  = OCC_W'(fill_reg);
                if (srch_reg)
                begin
                    // a match is held back until the next one shows whether it is last
                    if (rd_data == key_reg)
                    begin
                        if (pend_reg)
                        begin
                            strobe_next = 1'b1;
                            status_next = STAT_MATCH;
                            data_next   = key_reg;
                            slot_next   = SLOT_W'(pend_slot_reg);
                            last_next   = 1'b0;
                        end
                        pend_next      = 1'b1;
                        pend_slot_next = cur_reg;
                    end
                end
                else
                begin
                    strobe_next = 1'b1;
                    status_next = STAT_LISTED;
                    data_next   = rd_data;
                    slot_next   = SLOT_W'(cur_reg);
                    last_next   = (left_reg == CNT_W'(1));
                end
                if (left_reg == CNT_W'(1))
                begin
                    state_next = srch_reg ? S_FIN : S_IDLE;
                end
            end

            S_FIN:
            begin
                strobe_next = 1'b1;
                occ_next    = OCC_W'(fill_reg);
                last_next   = 1'b1;
                if (pend_reg)
                begin
                    status_next = STAT_MATCH;
                    data_next   = key_reg;
                    slot_next   = SLOT_W'(pend_slot_reg);
                end
                else
                begin
                    status_next = STAT_NOMATCH;
                    data_next   = '0;
                    slot_next   = '0;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            pend_reg   <= pend_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        left_reg      <= left_next;
        key_reg       <= key_next;
        srch_reg      <= srch_next;
        pend_slot_reg <= pend_slot_next;
        status_reg    <= status_next;
        data_reg      <= data_next;
        slot_reg      <= slot_next;
        occ_reg       <= occ_next;
        last_reg      <= last_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign strobe    = strobe_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign slot      = slot_reg;
    assign occupancy = occ_reg;
    assign last      = last_reg;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for circular_queue_with_search: a directed table, then random command words.
// Keeps its own ring model and checks every result word on strobe. Depends on cqs_pkg and circular_queue_with_search.
module tb_top;
    import cqs_pkg::*;

    localparam int LIMIT        = 200000;
    localparam int RANDOM_WORDS = 300;
    localparam int PLAN_ROWS    = 23;

    typedef struct packed {
        status_t                   status;
        logic signed [WORD_W-1:0]  data;
        logic [SLOT_W-1:0]         slot;
        logic [OCC_W-1:0]          occupancy;
        logic                      last;
    } result_t;

    // typed_in rows carry a single known result: slot 0, last set
    typedef struct packed {
        kind_t                     kind;
        logic signed [WORD_W-1:0]  value;
        logic                      typed_in;
        status_t                   status;
        logic signed [WORD_W-1:0]  data;
        logic [OCC_W-1:0]          occupancy;
    } plan_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic [KIND_W-1:0]             kind;
    logic signed [WORD_W-1:0]      value;
    logic                          busy;
    logic                          strobe;
    logic [STATUS_W-1:0]           status;
    logic signed [WORD_W-1:0]      data;
    logic [SLOT_W-1:0]             slot;
    logic [OCC_W-1:0]              occupancy;
    logic                          last;

    logic signed [WORD_W-1:0]      ring_mem [DEPTH];
    logic [PTR_W-1:0]              ring_head = '0;
    logic [PTR_W-1:0]              ring_tail = '0;
    int                            ring_fill = 0;
    result_t                       due_results [$];
    int                            mismatch_count = 0;
    int                            cycle_count = 0;

    plan_row_t plan [PLAN_ROWS] = '{
        '{KIND_DEQ,  32'sh0000_0000, 1'b1, STAT_EMPTY,   32'sh0000_0000, 4'd0},
        '{KIND_DISP, 32'sh1234_5678, 1'b1, STAT_EMPTY,   32'sh0000_0000, 4'd0},
        '{KIND_SRCH, 32'sh0000_0000, 1'b1, STAT_NOMATCH, 32'sh0000_0000, 4'd0},
        '{KIND_ENQ,  32'sh8000_0000, 1'b1, STAT_DONE,    32'sh0000_0000, 4'd1},
        '{KIND_ENQ,  32'sh7FFF_FFFF, 1'b1, STAT_DONE,    32'sh0000_0000, 4'd2},
        '{KIND_ENQ,  32'sh0000_0000, 1'b1, STAT_DONE,    32'sh0000_0000, 4'd3},
        '{KIND_ENQ,  32'shFFFF_FFFF, 1'b1, STAT_DONE,    32'sh0000_0000, 4'd4},
        '{KIND_ENQ,  32'sh7FFF_FFFF, 1'b1, STAT_DONE,    32'sh0000_0000, 4'd5},
        '{KIND_ENQ,  32'sh5555_5555, 1'b1, STAT_DONE,    32'sh0000_0000, 4'd6},
        '{KIND_ENQ,  32'shAAAA_AAAA, 1'b1, STAT_DONE,    32'sh0000_0000, 4'd7},
        '{KIND_ENQ,  32'sh1234_5678, 1'b1, STAT_DONE,    32'sh0000_0000, 4'd8},
        '{KIND_ENQ,  32'sh0BAD_F00D, 1'b1, STAT_FULL,    32'sh0000_0000, 4'd8},
        '{KIND_SRCH, 32'sh7FFF_FFFF, 1'b0, STAT_DONE,    32'sh0000_0000, 4'd0},
        '{KIND_SRCH, 32'sh8000_0000, 1'b0, STAT_DONE,    32'sh0000_0000, 4'd0},
        '{KIND_SRCH, 32'sh0000_0001, 1'b1, STAT_NOMATCH, 32'sh0000_0000, 4'd8},
        '{KIND_DISP, 32'sh0000_0000, 1'b0, STAT_DONE,    32'sh0000_0000, 4'd0},
        '{KIND_DEQ,  32'sh0000_0000, 1'b1, STAT_DONE,    32'sh8000_0000, 4'd7},
        '{KIND_DEQ,  32'shFFFF_FFFF, 1'b1, STAT_DONE,    32'sh7FFF_FFFF, 4'd6},
        '{KIND_ENQ,  32'sh0000_0005, 1'b1, STAT_DONE,    32'sh0000_0000, 4'd7},
        '{KIND_ENQ,  32'sh0000_0005, 1'b1, STAT_DONE,    32'sh0000_0000, 4'd8},
        '{KIND_DISP, 32'sh0000_0000, 1'b0, STAT_DONE,    32'sh0000_0000, 4'd0},
        '{KIND_SRCH, 32'sh0000_0005, 1'b0, STAT_DONE,    32'sh0000_0000, 4'd0},
        '{KIND_SRCH, 32'shFFFF_FFFF, 1'b0, STAT_DONE,    32'sh0000_0000, 4'd0}
    };

    circular_queue_with_search DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .value     (value),
        .busy      (busy),
        .strobe    (strobe),
        .status    (status),
        .data      (data),
        .slot      (slot),
        .occupancy (occupancy),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic void note_result(input status_t s, input logic signed [WORD_W-1:0] d,
                                        input logic [SLOT_W-1:0] sl, input logic l);
        result_t r;
        r.status    = s;
        r.data      = d;
        r.slot      = sl;
        r.occupancy = OCC_W'(ring_fill);
        r.last      = l;
        due_results.push_back(r);
    endfunction

    // ring model: updates state and queues the result words of one command
    function automatic void apply_to_ring(input kind_t k, input logic signed [WORD_W-1:0] v);
        logic [PTR_W-1:0]         p;
        logic signed [WORD_W-1:0] word;
        int                       hits;
        int                       seen;
        p    = ring_head;
        hits = 0;
        seen = 0;
        case (k)
            KIND_ENQ:
            begin
                if (ring_fill == DEPTH)
                begin
                    note_result(STAT_FULL, '0, '0, 1'b1);
                end
                else
                begin
                    ring_mem[ring_tail] = v;
                    ring_tail = wrap_inc(ring_tail);
                    ring_fill++;
                    note_result(STAT_DONE, '0, '0, 1'b1);
                end
            end
            KIND_DEQ:
            begin
                if (ring_fill == 0)
                begin
                    note_result(STAT_EMPTY, '0, '0, 1'b1);
                end
                else
                begin
                    word = ring_mem[ring_head];
                    ring_head = wrap_inc(ring_head);
                    ring_fill--;
                    note_result(STAT_DONE, word, '0, 1'b1);
                end
            end
            KIND_SRCH:
            begin
                for (int i = 0; i < ring_fill; i++)
                begin
                    if (ring_mem[p] == v)
                    begin
                        hits++;
                    end
                    p = wrap_inc(p);
                end
                if (hits == 0)
                begin
                    note_result(STAT_NOMATCH, '0, '0, 1'b1);
                end
                p = ring_head;
                for (int i = 0; i < ring_fill; i++)
                begin
                    if (ring_mem[p] == v)
                    begin
                        seen++;
                        note_result(STAT_MATCH, v, p, seen == hits);
                    end
                    p = wrap_inc(p);
                end
            end
            default:
            begin
                if (ring_fill == 0)
                begin
                    note_result(STAT_EMPTY, '0, '0, 1'b1);
                end
                for (int i = 0; i < ring_fill; i++)
                begin
                    note_result(STAT_LISTED, ring_mem[p], p, i == ring_fill - 1);
                    p = wrap_inc(p);
                end
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            return $urandom;
        end
        if (sel < 6)
        begin
            return $urandom_range(0, 3);
        end
        if (sel == 6)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0000_0000;
                default: return 32'shFFFF_FFFF;
            endcase
        end
        if (ring_fill > 0)
        begin
            return ring_mem[PTR_W'((int'(ring_head) + $urandom_range(0, ring_fill - 1))
                                   % DEPTH)];
        end
        return $urandom;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_word(input kind_t k, input logic signed [WORD_W-1:0] v, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        kind  <= k;
        value <= v;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        apply_to_ring(k, v);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (due_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t exp_r;
        if (rst_n && strobe)
        begin
            if (due_results.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected word status %0d data %0d slot %0d",
                                        status, data, slot));
            end
            else
            begin
                exp_r = due_results.pop_front();
                if (status !== exp_r.status)
                    flag_mismatch($sformatf("status %0d exp %0d", status, exp_r.status));
                if (data !== exp_r.data)
                    flag_mismatch($sformatf("data %0d exp %0d", data, exp_r.data));
                if (slot !== exp_r.slot)
                    flag_mismatch($sformatf("slot %0d exp %0d", slot, exp_r.slot));
                if (occupancy !== exp_r.occupancy)
                    flag_mismatch($sformatf("occupancy %0d exp %0d", occupancy,
                                            exp_r.occupancy));
                if (last !== exp_r.last)
                    flag_mismatch($sformatf("last %0b exp %0b", last, exp_r.last));
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        result_t typed_r;
        kind_t   k;
        int      r;
        int      stretch;
        bit      grow;
        bit      burst;
        start   = 1'b0;
        kind    = KIND_ENQ;
        value   = '0;
        rst_n   = 1'b0;
        stretch = 0;
        grow    = 1'b1;
        burst   = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            send_word(plan[i].kind, plan[i].value, pick_gap());
            if (plan[i].typed_in)
            begin
                typed_r.status    = plan[i].status;
                typed_r.data      = plan[i].data;
                typed_r.slot      = '0;
                typed_r.occupancy = plan[i].occupancy;
                typed_r.last      = 1'b1;
                due_results[due_results.size() - 1] = typed_r;
            end
        end
        drain();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (stretch == 0)
            begin
                stretch = $urandom_range(15, 50);
                grow    = 1'($urandom_range(0, 1));
                burst   = ($urandom_range(0, 4) == 0);
            end
            stretch--;
            if (n % 100 == 50)
            begin
                drain();
            end
            r = $urandom_range(0, 99);
            if (grow)
                k = (r < 50) ? KIND_ENQ : (r < 65) ? KIND_DEQ : (r < 85) ? KIND_SRCH : KIND_DISP;
            else
                k = (r < 15) ? KIND_ENQ : (r < 55) ? KIND_DEQ : (r < 80) ? KIND_SRCH : KIND_DISP;
            send_word(k, pick_value(), burst ? 0 : pick_gap());
        end

        drain();
        repeat (DEPTH + 4) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
rtl/cqs_pkg.sv
rtl/cqs_ram.sv
rtl/circular_queue_with_search.sv
tb/tb_top.sv
